@@ design/clock_motor_homing_controller_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Clock motor homing controller assertion macros
// Concurrent assertion wrappers used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef CLOCK_MOTOR_HOMING_CONTROLLER_UNIT_MACROS_SVH
`define CLOCK_MOTOR_HOMING_CONTROLLER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CHM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHM_ASSERT(label, prop, msg)
`define CHM_ASSERT_RST(label, prop, msg)
`endif

`endif

@@ design/chm_pkg.sv @@
// ----------------------------------------------------------------------------
// Clock motor homing controller package
// Types, codes and constants shared by the controller modules.
// ----------------------------------------------------------------------------
package chm_pkg;

  typedef enum logic [2:0] {
    MODE_STOP = 3'd0,
    MODE_FWD  = 3'd1,
    MODE_BACK = 3'd2,
    MODE_CAL  = 3'd3,
    MODE_FIND = 3'd4
  } mode_e_t;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_FWD   = 3'd1,
    OP_BACK  = 3'd2,
    OP_SPEED = 3'd3,
    OP_STOP  = 3'd4,
    OP_HOME  = 3'd5,
    OP_CAL   = 3'd6
  } opcode_t;

  localparam logic [1:0] DRV_NONE = 2'b00;
  localparam logic [1:0] DRV_FWD  = 2'b01;
  localparam logic [1:0] DRV_REV  = 2'b10;

  localparam logic [7:0] HOME_TARGET = 8'h92;
  localparam logic [7:0] HOUR_MASK   = 8'hF0;
  localparam logic [7:0] NEAR_SPEED  = 8'd3;
  localparam logic [7:0] SLOW_LIMIT  = 8'd2;
  localparam logic [7:0] ALL_ONES    = 8'hFF;
  localparam logic [7:0] START_SPEED = 8'd1;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] switches;
    logic [7:0] speed_value;
  } item_t;

  typedef struct packed {
    logic       drive_forward;
    logic       drive_reverse;
    logic [2:0] mode_now;
    logic       all_seen;
  } result_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

@@ design/chm_in_stage.sv @@
// ----------------------------------------------------------------------------
// Clock motor homing controller input stage
// Registers one input transaction and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module chm_in_stage
  import chm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      in_item,
  input  logic       advance,
  output stage_ctl_t ctl,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign ctl.valid   = valid_r;
  assign ctl.advance = advance;
  assign item        = item_r;

endmodule

@@ design/chm_core.sv @@
// ----------------------------------------------------------------------------
// Clock motor homing controller core
// Holds the motor state and applies one transaction per advance.
// ----------------------------------------------------------------------------
module chm_core
  import chm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  stage_ctl_t ctl,
  input  item_t      item,
  output result_t    result
);

  logic       disabled_r;
  mode_e_t    mode_r,        mode_nxt;
  logic [7:0] sw_now_r,      sw_now_nxt;
  logic [7:0] sw_before_r,   sw_before_nxt;
  logic [7:0] period_r,      period_nxt;
  logic [7:0] delay_r,       delay_nxt;
  logic [7:0] seen_high_r,   seen_high_nxt;
  logic [7:0] seen_low_r,    seen_low_nxt;
  logic [1:0] drive_r,       drive_nxt;
  logic       pulse_hit;
  logic       seen_cur;
  logic [7:0] delay_dec;
  logic [7:0] sw;

  assign pulse_hit = (delay_r == period_r);
  assign seen_cur  = ((seen_high_r & seen_low_r) == ALL_ONES);
  assign delay_dec = delay_r - 8'd1;
  assign sw        = item.switches;

  always_comb begin
    mode_nxt      = mode_r;
    sw_now_nxt    = sw_now_r;
    sw_before_nxt = sw_before_r;
    period_nxt    = period_r;
    delay_nxt     = delay_r;
    seen_high_nxt = seen_high_r;
    seen_low_nxt  = seen_low_r;
    drive_nxt     = drive_r;
    case (opcode_t'(item.opcode))
      OP_TICK: begin
        sw_before_nxt = sw_now_r;
        sw_now_nxt    = sw;
        case (mode_r)
          MODE_FWD: begin
            drive_nxt = pulse_hit ? DRV_FWD : DRV_NONE;
          end
          MODE_BACK: begin
            drive_nxt = pulse_hit ? DRV_REV : DRV_NONE;
          end
          MODE_CAL: begin
            if (sw != sw_now_r) begin
              seen_high_nxt = seen_high_r | sw;
              seen_low_nxt  = seen_low_r | ~sw;
              if ((seen_high_nxt & seen_low_nxt) == ALL_ONES) begin
                mode_nxt = MODE_FIND;
              end
            end
            drive_nxt = pulse_hit ? DRV_FWD : DRV_NONE;
          end
          MODE_FIND: begin
            if (sw == HOME_TARGET) begin
              mode_nxt  = MODE_STOP;
              drive_nxt = DRV_NONE;
            end else if (((sw & HOUR_MASK) == (HOME_TARGET & HOUR_MASK)) &&
                         (period_r < SLOW_LIMIT)) begin
              period_nxt = NEAR_SPEED;
              drive_nxt  = DRV_NONE;
            end else begin
              drive_nxt = pulse_hit ? DRV_REV : DRV_NONE;
            end
          end
          default: begin
            drive_nxt = DRV_NONE;
          end
        endcase
        delay_nxt = (delay_dec == 8'd0) ? period_nxt : delay_dec;
      end
      OP_FWD: begin
        if (!disabled_r) begin
          mode_nxt = MODE_FWD;
        end
      end
      OP_BACK: begin
        if (!disabled_r) begin
          mode_nxt = MODE_BACK;
        end
      end
      OP_SPEED: begin
        if (!disabled_r) begin
          period_nxt = item.speed_value;
          delay_nxt  = item.speed_value;
        end
      end
      OP_STOP: begin
        mode_nxt = MODE_STOP;
      end
      OP_HOME: begin
        if (disabled_r) begin
          mode_nxt = MODE_STOP;
        end else begin
          period_nxt = START_SPEED;
          delay_nxt  = START_SPEED;
          mode_nxt   = MODE_FIND;
        end
      end
      OP_CAL: begin
        if (!seen_cur) begin
          if (!disabled_r) begin
            period_nxt = START_SPEED;
            delay_nxt  = START_SPEED;
          end
          mode_nxt = MODE_CAL;
        end else if (disabled_r) begin
          mode_nxt = MODE_STOP;
        end else begin
          period_nxt = START_SPEED;
          delay_nxt  = START_SPEED;
          mode_nxt   = MODE_FIND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disabled_r <= 1'b0;
    end else if (cfg_we) begin
      disabled_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_STOP;
      sw_now_r    <= '0;
      sw_before_r <= '0;
      period_r    <= '0;
      delay_r     <= '0;
      seen_high_r <= '0;
      seen_low_r  <= '0;
      drive_r     <= DRV_NONE;
    end else if (ctl.valid && ctl.advance) begin
      mode_r      <= mode_nxt;
      sw_now_r    <= sw_now_nxt;
      sw_before_r <= sw_before_nxt;
      period_r    <= period_nxt;
      delay_r     <= delay_nxt;
      seen_high_r <= seen_high_nxt;
      seen_low_r  <= seen_low_nxt;
      drive_r     <= drive_nxt;
    end
  end

  assign result.drive_forward = drive_nxt[0];
  assign result.drive_reverse = drive_nxt[1];
  assign result.mode_now      = mode_nxt;
  assign result.all_seen      = ((seen_high_nxt & seen_low_nxt) == ALL_ONES);

endmodule

@@ design/chm_out_stage.sv @@
// ----------------------------------------------------------------------------
// Clock motor homing controller output stage
// Registers one result transaction and holds it until it is taken.
// ----------------------------------------------------------------------------
module chm_out_stage
  import chm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load_valid,
  input  result_t load_result,
  output logic    slot_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result
);

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  assign slot_free = !valid_r || out_ready;
  assign valid_nxt = slot_free ? load_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && load_valid) begin
      result_r <= load_result;
    end
  end

  assign out_valid = valid_r;
  assign result    = result_r;

endmodule

@@ design/clock_motor_homing_controller_unit.sv @@
// ----------------------------------------------------------------------------
// Clock motor homing controller top level
// Path: a transaction is registered in the input stage, applied by the core and registered in the output stage.
// Throughput: one transaction per cycle while the output side is not stalled.
// Reset: synchronous active-low rst_n clears the core state, the stage valid flags and the register.
// ----------------------------------------------------------------------------
`include "clock_motor_homing_controller_unit_macros.svh"

module clock_motor_homing_controller_unit
  import chm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_opcode,
  input  logic [7:0] in_switches,
  input  logic [7:0] in_speed_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_drive_forward,
  output logic       out_drive_reverse,
  output logic [2:0] out_mode_now,
  output logic       out_all_seen
);

  item_t      in_item;
  item_t      item;
  stage_ctl_t ctl;
  result_t    core_result;
  result_t    out_result;
  logic       slot_free;

  assign in_item.opcode      = in_opcode;
  assign in_item.switches    = in_switches;
  assign in_item.speed_value = in_speed_value;

  chm_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (slot_free),
    .ctl      (ctl),
    .item     (item)
  );

  chm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .item      (item),
    .result    (core_result)
  );

  chm_out_stage u_out_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_valid  (ctl.valid),
    .load_result (core_result),
    .slot_free   (slot_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (out_result)
  );

  assign out_drive_forward = out_result.drive_forward;
  assign out_drive_reverse = out_result.drive_reverse;
  assign out_mode_now      = out_result.mode_now;
  assign out_all_seen      = out_result.all_seen;

  `CHM_ASSERT(a_drive_exclusive, out_valid |-> !(out_drive_forward && out_drive_reverse), "both drives active")
  `CHM_ASSERT(a_mode_range, out_valid |-> (out_mode_now <= 3'd4), "mode out of range")
  `CHM_ASSERT(a_seen_sticky, (out_valid && out_all_seen) |=> out_all_seen, "all_seen fell")
  `CHM_ASSERT_RST(a_reset_empty, !rst_n |=> (!out_valid && in_ready), "stages not empty after reset")

endmodule

@@ test/clock_motor_homing_controller_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock motor homing controller testbench
// Sends directed and random commands and ticks through the valid/ready input,
// predicts the drives, mode and calibration flag for each transaction, and
// checks every result in order while both sides idle and stall at random in most tests.
// ----------------------------------------------------------------------------
module clock_motor_homing_controller_unit_tb;
  import chm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_opcode = OP_TICK;
  logic [7:0] in_switches = 8'h00;
  logic [7:0] in_speed_value = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_drive_forward;
  logic       out_drive_reverse;
  logic [2:0] out_mode_now;
  logic       out_all_seen;

  clock_motor_homing_controller_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_switches      (in_switches),
    .in_speed_value   (in_speed_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_drive_forward(out_drive_forward),
    .out_drive_reverse(out_drive_reverse),
    .out_mode_now     (out_mode_now),
    .out_all_seen     (out_all_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted controller state
  logic       pred_disabled = 1'b0;
  mode_e_t    pred_mode = MODE_STOP;
  logic [7:0] pred_sw_now = 8'h00;
  logic [7:0] pred_sw_prev = 8'h00;
  logic [7:0] pred_period = 8'h00;
  logic [7:0] pred_delay = 8'h00;
  logic [7:0] pred_seen_high = 8'h00;
  logic [7:0] pred_seen_low = 8'h00;
  logic [1:0] pred_drive = DRV_NONE;

  result_t expected_outputs[$];
  bit      src_idle = 1'b0;
  bit      sink_idle = 1'b0;
  int      items_sent = 0;
  int      results_checked = 0;
  int      reg_writes = 0;
  int      mismatches = 0;
  int      cycle_count = 0;

  function automatic bit every_bit_seen();
    return (pred_seen_high & pred_seen_low) == ALL_ONES;
  endfunction

  function automatic logic [1:0] pulse_if_due(logic [1:0] dir);
    return (pred_delay == pred_period) ? dir : DRV_NONE;
  endfunction

  function automatic void load_period(logic [7:0] value);
    if (!pred_disabled) begin
      pred_period = value;
      pred_delay = value;
    end
  endfunction

  function automatic void seek_home();
    if (pred_disabled) begin
      pred_mode = MODE_STOP;
    end else begin
      load_period(START_SPEED);
      pred_mode = MODE_FIND;
    end
  endfunction

  function automatic result_t predict_motor_outputs(logic [2:0] op, logic [7:0] sw,
                                                    logic [7:0] spd);
    result_t r;
    case (op)
      OP_TICK: begin
        pred_sw_prev = pred_sw_now;
        pred_sw_now = sw;
        case (pred_mode)
          MODE_FWD: pred_drive = pulse_if_due(DRV_FWD);
          MODE_BACK: pred_drive = pulse_if_due(DRV_REV);
          MODE_CAL: begin
            if (pred_sw_now != pred_sw_prev) begin
              pred_seen_high = pred_seen_high | pred_sw_now;
              pred_seen_low = pred_seen_low | ~pred_sw_now;
              if (every_bit_seen()) pred_mode = MODE_FIND;
            end
            pred_drive = pulse_if_due(DRV_FWD);
          end
          MODE_FIND: begin
            if (pred_sw_now == HOME_TARGET) begin
              pred_mode = MODE_STOP;
              pred_drive = DRV_NONE;
            end else if ((pred_sw_now & HOUR_MASK) == (HOME_TARGET & HOUR_MASK) &&
                         pred_period < SLOW_LIMIT) begin
              pred_period = NEAR_SPEED;
              pred_drive = DRV_NONE;
            end else begin
              pred_drive = pulse_if_due(DRV_REV);
            end
          end
          default: pred_drive = DRV_NONE;
        endcase
        pred_delay = pred_delay - 8'd1;
        if (pred_delay == 8'd0) pred_delay = pred_period;
      end
      OP_FWD: if (!pred_disabled) pred_mode = MODE_FWD;
      OP_BACK: if (!pred_disabled) pred_mode = MODE_BACK;
      OP_SPEED: load_period(spd);
      OP_STOP: pred_mode = MODE_STOP;
      OP_HOME: seek_home();
      OP_CAL: begin
        if (!every_bit_seen()) begin
          load_period(START_SPEED);
          pred_mode = MODE_CAL;
        end else begin
          seek_home();
        end
      end
      default: ;
    endcase
    r.drive_forward = pred_drive[0];
    r.drive_reverse = pred_drive[1];
    r.mode_now = pred_mode;
    r.all_seen = every_bit_seen();
    return r;
  endfunction

  function automatic void note_mismatch(string field, int want, int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("Mismatch in %s at result %0d: expected %0h, got %0h",
               field, results_checked, want, got);
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("clock_motor_homing_controller_unit_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (expected_outputs.size() == 0) begin
        note_mismatch("unexpected result", 0, 1);
      end else begin
        want = expected_outputs.pop_front();
        if (out_drive_forward !== want.drive_forward)
          note_mismatch("drive_forward", want.drive_forward, out_drive_forward);
        if (out_drive_reverse !== want.drive_reverse)
          note_mismatch("drive_reverse", want.drive_reverse, out_drive_reverse);
        if (out_mode_now !== want.mode_now)
          note_mismatch("mode_now", want.mode_now, out_mode_now);
        if (out_all_seen !== want.all_seen)
          note_mismatch("all_seen", want.all_seen, out_all_seen);
      end
    end
  end

  // Result side: while sink_idle is set, a fresh stall is drawn for every result.
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = sink_idle ? $urandom_range(0, 10) : 0;
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid));
      @(negedge clk);
    end
  end

  task automatic send_item(logic [2:0] op, logic [7:0] sw, logic [7:0] spd);
    int gap;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode = op;
    in_switches = sw;
    in_speed_value = spd;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_outputs.push_back(predict_motor_outputs(op, sw, spd));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_outputs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_clock_disabled(logic value);
    wait_idle();
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    pred_disabled = value;
    reg_writes++;
  endtask

  function automatic logic [7:0] random_switches();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return HOME_TARGET;
    if (pick < 5) return {HOME_TARGET[7:4], 4'($urandom_range(0, 15))};
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] random_speed();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 4));
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly a command followed by a run of ticks, with odd single items as noise.
  task automatic run_random_traffic(int count);
    int sent;
    int run;
    logic [2:0] op;
    sent = 0;
    while (sent < count) begin
      src_idle = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
        sent++;
      end else begin
        op = 3'($urandom_range(OP_FWD, OP_CAL));
        send_item(op, 8'($urandom_range(0, 255)), random_speed());
        run = $urandom_range(1, 12);
        repeat (run) send_item(OP_TICK, random_switches(), 8'($urandom_range(0, 255)));
        sent += run + 1;
      end
    end
  endtask

  task automatic test_disabled_commands();
    set_clock_disabled(1'b1);
    send_item(OP_FWD, 8'h00, 8'h00);
    send_item(OP_BACK, 8'h00, 8'h00);
    send_item(OP_SPEED, 8'h00, 8'hFF);
    send_item(OP_HOME, 8'h00, 8'h00);
    send_item(OP_TICK, 8'h00, 8'h00);
    send_item(OP_CAL, 8'h00, 8'h00);
    send_item(OP_TICK, 8'hFF, 8'h00);
    send_item(OP_STOP, 8'h00, 8'h00);
    send_item(OP_UNUSED, 8'hFF, 8'hFF);
  endtask

  task automatic test_basic_motion();
    set_clock_disabled(1'b0);
    send_item(OP_SPEED, 8'h00, 8'h00);
    send_item(OP_FWD, 8'h00, 8'h00);
    repeat (3) send_item(OP_TICK, 8'h00, 8'h00);
    send_item(OP_SPEED, 8'h00, 8'd2);
    send_item(OP_BACK, 8'h00, 8'h00);
    repeat (3) send_item(OP_TICK, 8'h0F, 8'h00);
    send_item(OP_UNUSED, 8'h00, 8'h00);
  endtask

  task automatic test_calibrate_and_home();
    send_item(OP_CAL, 8'h00, 8'h00);
    send_item(OP_TICK, 8'hAA, 8'h00);
    send_item(OP_TICK, 8'h55, 8'h00);
    send_item(OP_TICK, 8'h9F, 8'h00);
    send_item(OP_TICK, 8'h13, 8'h00);
    send_item(OP_TICK, HOME_TARGET, 8'h00);
    send_item(OP_CAL, 8'h00, 8'h00);
    send_item(OP_TICK, HOME_TARGET, 8'h00);
    send_item(OP_HOME, 8'h00, 8'h00);
    send_item(OP_TICK, 8'h00, 8'h00);
    send_item(OP_STOP, 8'h00, 8'h00);
  endtask

  task automatic test_random_running();
    set_clock_disabled(1'b0);
    run_random_traffic(500);
  endtask

  task automatic test_random_clock_disabled();
    set_clock_disabled(1'b1);
    run_random_traffic(250);
  endtask

  task automatic test_random_reenabled();
    set_clock_disabled(1'b0);
    run_random_traffic(500);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    test_disabled_commands();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    test_basic_motion();
    src_idle = 1'b1;
    test_calibrate_and_home();
    test_random_running();
    test_random_clock_disabled();
    test_random_reenabled();
    wait_idle();
    $display("Covered %0d transactions and %0d results over %0d register writes.",
             items_sent, results_checked, reg_writes);
    $display("Mismatches found: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("clock_motor_homing_controller_unit_tb OK");
    end else begin
      $display("clock_motor_homing_controller_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
